// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/sha1_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;

  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_FINISH  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        status;
    logic        last;
  } out_word_t;

  // Control from sequencer to round unit.
  typedef struct packed {
    logic       start;   // load working vars from hash
    logic       step;    // run one round
    logic [6:0] rnd;     // round number 0..79
    logic       fold;    // add working vars into hash
    logic       init;    // reload initial values
  } rnd_ctl_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0:    init_h = 32'h67452301;
      3'd1:    init_h = 32'hEFCDAB89;
      3'd2:    init_h = 32'h98BADCFE;
      3'd3:    init_h = 32'h10325476;
      default: init_h = 32'hC3D2E1F0;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20)      round_k = 32'h5A827999;
    else if (r < 7'd40) round_k = 32'h6ED9EBA1;
    else if (r < 7'd60) round_k = 32'h8F1BBCDC;
    else                round_k = 32'hCA62C1D6;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha1_byte_stream_hasher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload               Handshake
// in       in   sha1_pkg::in_word_t   in_valid / in_ready
// out      out  sha1_pkg::out_word_t  out_valid / out_ready
// The 64th byte of a block starts its compression: the schedule words are
// gathered byte by byte, then 80 rounds of the shared round unit, then a fold.
// Finish pads and compresses one or two blocks, then emits five words, one per
// cycle when out_ready is high; once done it re-emits them, and a failed stream emits one status word.
// Reset is synchronous; it reloads the initial chaining values at once.
// in_ready is low while a block compresses or results drain.
module sha1_byte_stream_hasher_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sha1_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sha1_pkg::out_word_t      out_data
);
  `include "assert_macros.svh"

  typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT}
    state_t;

  state_t      state;
  logic [7:0]  mem [64];
  logic [5:0]  fill;
  logic [63:0] bit_cnt;
  logic        done, bad, finishing, second;
  logic [6:0]  rnd;
  logic [31:0] wq [16];
  logic [31:0] w_cur, w_new, rd_word;
  logic [2:0]  emit_idx;
  logic        emit_fail;
  logic [7:0]  pad_byte;
  sha1_pkg::rnd_ctl_t ctl;

  // Message schedule: sliding window of 16 words, built from memory.
  always_comb begin
    w_new = wq[13] ^ wq[8] ^ wq[2] ^ wq[0];
    w_new = {w_new[30:0], w_new[31]};
    w_cur = (rnd < 7'd16) ? wq[rnd[3:0]] : w_new;
  end

  assign ctl.start = (state == ST_LOAD);
  assign ctl.step  = (state == ST_ROUND);
  assign ctl.rnd   = rnd;
  assign ctl.fold  = (state == ST_FOLD);
  assign ctl.init  = (state == ST_IDLE) && in_valid && in_ready &&
                     in_data.req_type == sha1_pkg::REQ_RESTART;

  sha1_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .w(w_cur), .rd_idx(emit_idx), .rd_word(rd_word)
  );

  assign in_ready  = (state == ST_IDLE) && !out_valid;

  // Pad byte at current fill: 0x80 first, zeros, then the length field.
  always_comb begin
    if (!second && fill == 6'd0 && !finishing)
      pad_byte = 8'h80;
    else if (fill >= 6'd56 && second)
      pad_byte = bit_cnt[8'(7'd63 - {fill[2:0], 3'b0}) -: 8];
    else
      pad_byte = 8'h00;
  end

  logic [5:0] load_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; fill <= '0; bit_cnt <= '0; done <= 1'b0; bad <= 1'b0;
      out_valid <= 1'b0; finishing <= 1'b0; second <= 1'b0; rnd <= '0;
      emit_idx <= '0; emit_fail <= 1'b0; load_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_valid && out_ready) begin
            if (emit_fail || emit_idx == 3'd4) out_valid <= 1'b0;
            else emit_idx <= emit_idx + 3'd1;
          end
          if (in_valid && in_ready) begin
            case (in_data.req_type)
              sha1_pkg::REQ_BYTE: begin
                if (done || bad) bad <= 1'b1;
                else begin
                  mem[fill] <= in_data.data_byte;
                  fill <= fill + 6'd1;
                  bit_cnt <= bit_cnt + 64'd8;
                  if (bit_cnt == 64'hFFFF_FFFF_FFFF_FFF8) bad <= 1'b1;
                  if (fill == 6'd63) begin
                    load_cnt <= '0; state <= ST_LOAD;
                  end
                end
              end
              sha1_pkg::REQ_FINISH: begin
                emit_idx <= '0;
                if (bad) begin
                  emit_fail <= 1'b1; out_valid <= 1'b1;
                end else if (done) begin
                  emit_fail <= 1'b0; out_valid <= 1'b1;
                end else begin
                  // Write 0x80 now; the rest is padded in ST_PAD.
                  mem[fill] <= 8'h80;
                  fill <= fill + 6'd1;
                  finishing <= 1'b1;
                  second <= (fill < 6'd56);
                  state <= (fill == 6'd63) ? ST_LOAD : ST_PAD;
                  load_cnt <= '0;
                end
              end
              sha1_pkg::REQ_RESTART: begin
                fill <= '0; bit_cnt <= '0; done <= 1'b0; bad <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_PAD: begin
          mem[fill] <= second ? pad_byte : 8'h00;
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            load_cnt <= '0; state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // Gather 16 words from memory, one byte per cycle.
          wq[load_cnt[5:2]] <= {wq[load_cnt[5:2]][23:0], mem[load_cnt]};
          load_cnt <= load_cnt + 6'd1;
          if (load_cnt == 6'd63) begin
            rnd <= '0; state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          // Hold the first 16 words in place; slide once expansion starts.
          if (rnd >= 7'd16) begin
            for (int i = 0; i < 15; i++) wq[i] <= wq[i + 1];
            wq[15] <= w_new;
          end
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= ST_FOLD;
        end
        ST_FOLD: begin
          fill <= '0;
          if (!finishing) state <= ST_IDLE;
          else if (!second) begin
            second <= 1'b1; state <= ST_PAD;
          end else begin
            finishing <= 1'b0; second <= 1'b0; done <= 1'b1;
            emit_fail <= 1'b0; emit_idx <= '0; out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.digest_word = emit_fail ? 32'd0 : rd_word;
    out_data.word_index  = emit_fail ? 3'd0 : emit_idx;
    out_data.status      = emit_fail;
    out_data.last        = emit_fail || emit_idx == 3'd4;
  end

  `ASSERT_IMPL(a_no_in_while_out, clk, rst, out_valid, !in_ready, "input taken while emitting")
  `ASSERT_ALWAYS(a_idx_range, clk, rst, emit_idx <= 3'd4, "word index out of range")
  `ASSERT_IMPL(a_fail_single, clk, rst, out_valid && emit_fail, emit_idx == 3'd0, "bad fail index")

endmodule
`default_nettype wire

// ----- hw/rtl/sha1_round.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared SHA-1 round datapath: one round per step, holds the chaining words.
module sha1_round (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha1_pkg::rnd_ctl_t ctl,
  input  wire logic [31:0]        w,
  input  wire logic [2:0]         rd_idx,
  output logic [31:0]             rd_word
);

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, t;

  always_comb begin
    if (ctl.rnd < 7'd20)
      f = (b & c) | (~b & d);
    else if (ctl.rnd >= 7'd40 && ctl.rnd < 7'd60)
      f = (b & c) | (b & d) | (c & d);
    else
      f = b ^ c ^ d;
    t = {a[26:0], a[31:27]} + f + e + w + sha1_pkg::round_k(ctl.rnd);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 5; i++) h[i] <= sha1_pkg::init_h(3'(i));
    end else if (ctl.fold) begin
      h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
      h[3] <= h[3] + d; h[4] <= h[4] + e;
    end
    if (ctl.start) begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
    end else if (ctl.step) begin
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
    end
  end

  always_comb begin
    case (rd_idx)
      3'd0:    rd_word = h[0];
      3'd1:    rd_word = h[1];
      3'd2:    rd_word = h[2];
      3'd3:    rd_word = h[3];
      default: rd_word = h[4];
    endcase
  end

endmodule
`default_nettype wire
